// File: sv/avnt_pkg.sv
// Package for the affine vertex and normal transform pipeline.
// Holds the payload structs, register indexes and pipeline constants.
// No dependencies.
package avnt_pkg;

  localparam int POS_W   = 24;
  localparam int NRM_W   = 16;
  localparam int COEF_W  = 16;
  localparam int CFG_W   = 64;
  localparam int NCFG_W  = 48;
  localparam int IDX_W   = 3;
  localparam int MAG_W   = 31;
  localparam int SQ_N    = 32;
  localparam int DIV_N   = 15;
  localparam int REM_W   = 46;
  localparam int LEN_W   = 32;

  localparam logic [IDX_W-1:0] CFG_ROW_X = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW_Y = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ROW_Z = 3'd2;
  localparam logic [IDX_W-1:0] CFG_NRM_X = 3'd3;
  localparam logic [IDX_W-1:0] CFG_NRM_Y = 3'd4;
  localparam logic [IDX_W-1:0] CFG_NRM_Z = 3'd5;

  localparam logic [CFG_W-1:0] ONE_AT_0 = 64'd4096;
  localparam logic [CFG_W-1:0] ONE_AT_1 = 64'd4096 << 16;
  localparam logic [CFG_W-1:0] ONE_AT_2 = 64'd4096 << 32;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } vertex_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_pos_x;
    logic signed [POS_W-1:0] out_pos_y;
    logic signed [POS_W-1:0] out_pos_z;
    logic signed [NRM_W-1:0] out_nrm_x;
    logic signed [NRM_W-1:0] out_nrm_y;
    logic signed [NRM_W-1:0] out_nrm_z;
  } result_t;

  // Data that rides alongside the square root and divider stages.
  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } side_t;

  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] r, input int k);
    coef = r[COEF_W*k +: COEF_W];
  endfunction

  // Trial bit of the square root stage k: 4^(31-k).
  function automatic logic [63:0] sq_bit(input int k);
    sq_bit = 64'd1 << (2 * (SQ_N - 1 - k));
  endfunction

endpackage

// File: sv/affine_vertex_normal_transform.sv
// Top level of the affine vertex and normal transform pipeline.
// Depends on avnt_pkg for payload types, register indexes and constants.
//
// One vertex is taken in every clock cycle (busy is always low) and its
// result appears on done/result once it has passed the registers below;
// the result is shown for one cycle only and must be taken then. The
// depth is set by the normal path: four stages of multiply, sum, scale
// and square, a register for the sum of squares, a 32-stage square root
// with one root bit per stage, a divider setup register, a 15-stage
// divider with one quotient bit per stage and the output register. The
// first of these registers loads at the request edge itself. Coefficient
// registers may only be written while the pipeline is empty.
module affine_vertex_normal_transform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  avnt_pkg::vertex_t                   vertex,
  output logic                                done,
  output avnt_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [avnt_pkg::IDX_W-1:0]          cfg_index,
  input  logic [avnt_pkg::CFG_W-1:0]          cfg_data
);
  import avnt_pkg::*;

  logic [CFG_W-1:0]  row [3];
  logic [NCFG_W-1:0] nrow [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]  <= ONE_AT_0;
      row[1]  <= ONE_AT_1;
      row[2]  <= ONE_AT_2;
      nrow[0] <= ONE_AT_0[NCFG_W-1:0];
      nrow[1] <= ONE_AT_1[NCFG_W-1:0];
      nrow[2] <= ONE_AT_2[NCFG_W-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_X: row[0]  <= cfg_data;
        CFG_ROW_Y: row[1]  <= cfg_data;
        CFG_ROW_Z: row[2]  <= cfg_data;
        CFG_NRM_X: nrow[0] <= cfg_data[NCFG_W-1:0];
        CFG_NRM_Y: nrow[1] <= cfg_data[NCFG_W-1:0];
        CFG_NRM_Z: nrow[2] <= cfg_data[NCFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: all products.
  logic                   v1;
  logic signed [39:0]     pp [3][3];
  logic signed [COEF_W-1:0] pt [3];
  logic signed [31:0]     np [3][3];

  logic signed [POS_W-1:0] pin [3];
  logic signed [NRM_W-1:0] nin [3];
  assign pin[0] = vertex.pos_x;
  assign pin[1] = vertex.pos_y;
  assign pin[2] = vertex.pos_z;
  assign nin[0] = vertex.nrm_x;
  assign nin[1] = vertex.nrm_y;
  assign nin[2] = vertex.nrm_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pt[i] <= coef(row[i], 3);
      for (int j = 0; j < 3; j++) begin
        pp[i][j] <= 40'(coef(row[i], j) * pin[j]);
        np[i][j] <= 32'(coef({16'd0, nrow[i]}, j) * nin[j]);
      end
    end
  end

  // Stage 2: position rounding and saturation, normal sums and magnitudes.
  logic                   v2;
  logic [POS_W-1:0]       pos2 [3];
  logic [32:0]            mag2 [3];
  logic [2:0]             neg2;
  logic signed [41:0]     psum [3];
  logic signed [29:0]     prnd [3];
  logic signed [33:0]     nsum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = 42'(pp[i][0]) + 42'(pp[i][1]) + 42'(pp[i][2])
              + (42'(pt[i]) <<< 12) + 42'sd2048;
      prnd[i] = 30'(psum[i] >>> 12);
      nsum[i] = 34'(np[i][0]) + 34'(np[i][1]) + 34'(np[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (prnd[i] > 30'sd8388607)       pos2[i] <= 24'h7fffff;
      else if (prnd[i] < -30'sd8388608) pos2[i] <= 24'h800000;
      else                              pos2[i] <= prnd[i][POS_W-1:0];
      neg2[i] <= nsum[i][33];
      mag2[i] <= nsum[i][33] ? 33'(-nsum[i]) : nsum[i][32:0];
    end
  end

  // Stage 3: halve all magnitudes when any of them reaches 2^31.
  logic                   v3;
  side_t                  sd3;
  logic                   big;
  assign big = (mag2[0][32:31] != 2'd0) || (mag2[1][32:31] != 2'd0)
            || (mag2[2][32:31] != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sd3.pos[i] <= pos2[i];
      sd3.mag[i] <= big ? mag2[i][MAG_W:1] : mag2[i][MAG_W-1:0];
    end
    sd3.neg <= neg2;
  end

  // Stage 4: squares.
  logic                   v4;
  side_t                  sd4;
  logic [61:0]            sqr [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    sd4 <= sd3;
    for (int i = 0; i < 3; i++) sqr[i] <= 62'(sd3.mag[i] * sd3.mag[i]);
  end

  // Square root line: stage 0 takes the sum of squares, each later
  // stage settles one root bit.
  logic               sq_v [SQ_N+1];
  side_t              sq_sd [SQ_N+1];
  logic [63:0]        sq_s [SQ_N+1];
  logic [63:0]        sq_r [SQ_N+1];
  logic [63:0]        sq_t [SQ_N];

  always_comb begin
    for (int k = 0; k < SQ_N; k++) sq_t[k] = sq_r[k] + sq_bit(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_N; k++) sq_v[k] <= 1'b0;
    end else begin
      sq_v[0] <= v4;
      for (int k = 0; k < SQ_N; k++) sq_v[k+1] <= sq_v[k];
    end
  end

  always_ff @(posedge clk) begin
    sq_sd[0] <= sd4;
    sq_s[0]  <= 64'(sqr[0]) + 64'(sqr[1]) + 64'(sqr[2]);
    sq_r[0]  <= 64'd0;
    for (int k = 0; k < SQ_N; k++) begin
      sq_sd[k+1] <= sq_sd[k];
      if (sq_s[k] >= sq_t[k]) begin
        sq_s[k+1] <= sq_s[k] - sq_t[k];
        sq_r[k+1] <= (sq_r[k] >> 1) + sq_bit(k);
      end else begin
        sq_s[k+1] <= sq_s[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
    end
  end

  // Divider line: three restoring dividers, one quotient bit per stage,
  // highest first. The quotient never exceeds 16384.
  logic               dv_v [DIV_N+1];
  side_t              dv_sd [DIV_N+1];
  logic [LEN_W-1:0]   dv_len [DIV_N+1];
  logic [REM_W-1:0]   dv_rem [DIV_N+1][3];
  logic [DIV_N-1:0]   dv_q [DIV_N+1][3];
  logic [REM_W-1:0]   dv_d [DIV_N];
  logic [LEN_W-1:0]   len;

  assign len = sq_r[SQ_N][LEN_W-1:0];

  always_comb begin
    for (int j = 0; j < DIV_N; j++)
      dv_d[j] = REM_W'(dv_len[j]) << (DIV_N - 1 - j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DIV_N; j++) dv_v[j] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SQ_N];
      for (int j = 0; j < DIV_N; j++) dv_v[j+1] <= dv_v[j];
    end
  end

  always_ff @(posedge clk) begin
    dv_sd[0]  <= sq_sd[SQ_N];
    dv_len[0] <= len;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (REM_W'(sq_sd[SQ_N].mag[i]) << 14) + REM_W'(len >> 1);
      dv_q[0][i]   <= '0;
    end
    for (int j = 0; j < DIV_N; j++) begin
      dv_sd[j+1]  <= dv_sd[j];
      dv_len[j+1] <= dv_len[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= dv_d[j]) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - dv_d[j];
          dv_q[j+1][i]   <= dv_q[j][i] | (DIV_N'(1) << (DIV_N - 1 - j));
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i];
        end
      end
    end
  end

  // Output register: apply signs, zero a degenerate normal.
  logic [NRM_W-1:0] nout [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_len[DIV_N] == '0)
        nout[i] = '0;
      else if (dv_sd[DIV_N].neg[i])
        nout[i] = NRM_W'(-{1'b0, dv_q[DIV_N][i]});
      else
        nout[i] = {1'b0, dv_q[DIV_N][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[DIV_N];
  end

  always_ff @(posedge clk) begin
    result.out_pos_x <= dv_sd[DIV_N].pos[0];
    result.out_pos_y <= dv_sd[DIV_N].pos[1];
    result.out_pos_z <= dv_sd[DIV_N].pos[2];
    result.out_nrm_x <= nout[0];
    result.out_nrm_y <= nout[1];
    result.out_nrm_z <= nout[2];
  end

endmodule
